// ===== design/begin_end_style_checker_core_assert.svh =====
// Assertion macros used by the checker FSM module.
`ifndef BEGIN_END_STYLE_CHECKER_CORE_ASSERT_SVH
`define BEGIN_END_STYLE_CHECKER_CORE_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define BESC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define BESC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BESC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/besc_pkg.sv =====
package besc_pkg;

    localparam int DEPTH_WIDTH     = 8;
    localparam int POSITION_WIDTH  = 32;
    localparam int CLASS_WIDTH     = 5;
    localparam int KW_CLASS_WIDTH  = 4;
    localparam int MASK_WIDTH      = 11;
    localparam int ADDR_WIDTH      = 3;
    localparam int DATA_WIDTH      = 32;
    localparam int IN_TDATA_WIDTH  = 40;
    localparam int OUT_TDATA_WIDTH = 80;

    localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = {DEPTH_WIDTH{1'b1}};
    localparam logic [MASK_WIDTH-1:0]  MASK_RESET = {MASK_WIDTH{1'b1}};

    // register index 0 (keyword_enable_mask), decoded on paddr[2]
    localparam logic REG_MASK_SEL = 1'b0;

    localparam logic [CLASS_WIDTH-1:0] CLS_OTHER        = 5'd0;
    localparam logic [CLASS_WIDTH-1:0] CLS_SPACE        = 5'd1;
    localparam logic [CLASS_WIDTH-1:0] CLS_COMB_PROC    = 5'd2;
    localparam logic [CLASS_WIDTH-1:0] CLS_FF_PROC      = 5'd6;
    localparam logic [CLASS_WIDTH-1:0] CLS_FOREACH      = 5'd7;
    localparam logic [CLASS_WIDTH-1:0] CLS_FOR          = 5'd8;
    localparam logic [CLASS_WIDTH-1:0] CLS_IF           = 5'd9;
    localparam logic [CLASS_WIDTH-1:0] CLS_WHILE        = 5'd10;
    localparam logic [CLASS_WIDTH-1:0] CLS_ALWAYS       = 5'd11;
    localparam logic [CLASS_WIDTH-1:0] CLS_ELSE         = 5'd12;
    localparam logic [CLASS_WIDTH-1:0] CLS_BEGIN        = 5'd13;
    localparam logic [CLASS_WIDTH-1:0] CLS_OPEN         = 5'd14;
    localparam logic [CLASS_WIDTH-1:0] CLS_CLOSE        = 5'd15;
    localparam logic [CLASS_WIDTH-1:0] CLS_AT           = 5'd16;
    localparam logic [CLASS_WIDTH-1:0] CLS_STAR         = 5'd17;

    typedef logic [MASK_WIDTH-1:0] t_mask;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_ALWAYS = 3'd1,
        PH_ELSE   = 3'd2,
        PH_COND   = 3'd3,
        PH_EXPECT = 3'd4
    } t_phase;

    typedef struct packed {
        logic [POSITION_WIDTH-1:0] pos;
        logic [CLASS_WIDTH-1:0]    cls;
    } t_token;

    // packed so that kw_pos lands in the low bits of tdata
    typedef struct packed {
        logic [CLASS_WIDTH-1:0]    off_cls;
        logic [POSITION_WIDTH-1:0] off_pos;
        logic [KW_CLASS_WIDTH-1:0] kw_cls;
        logic [POSITION_WIDTH-1:0] kw_pos;
    } t_result;

    function automatic logic kw_enabled(input t_mask mask, input logic [CLASS_WIDTH-1:0] cls);
        logic [CLASS_WIDTH-1:0] off;
        off = cls - CLS_COMB_PROC;
        return (cls >= CLS_COMB_PROC) && (cls <= CLS_ELSE) && mask[off[3:0]];
    endfunction

endpackage

// ===== design/besc_cfg.sv =====
module besc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [besc_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [besc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [besc_pkg::DATA_WIDTH-1:0] prdata,
    output logic                            pready,
    output besc_pkg::t_mask                 o_mask
);
    import besc_pkg::*;

    t_mask r_mask;
    logic  w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_MASK_SEL);

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (w_wr) begin
            r_mask <= pwdata[MASK_WIDTH-1:0];
        end
    end

    always @* begin
        prdata = '0;
        if (paddr[2] == REG_MASK_SEL) begin
            prdata = DATA_WIDTH'(r_mask);
        end
    end

    assign o_mask = r_mask;

endmodule

// ===== design/besc_in.sv =====
module besc_in (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  besc_pkg::t_token i_tok,
    output logic             o_ready,
    input  logic             i_advance,
    output logic             o_valid,
    output besc_pkg::t_token o_tok
);
    import besc_pkg::*;

    logic   r_valid;
    t_token r_tok;

    assign o_ready = !r_valid || i_advance;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tok <= i_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

// ===== design/besc_fsm.sv =====
`include "begin_end_style_checker_core_assert.svh"

module besc_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  besc_pkg::t_mask   i_mask,
    input  logic              i_advance,
    input  besc_pkg::t_token  i_tok,
    output logic              o_viol,
    output besc_pkg::t_result o_result
);
    import besc_pkg::*;

    t_phase                    r_phase, n_phase;
    logic [DEPTH_WIDTH-1:0]    r_depth, n_depth;
    logic [POSITION_WIDTH-1:0] r_kpos, n_kpos;
    logic [KW_CLASS_WIDTH-1:0] r_kcls, n_kcls;
    logic                      w_viol;
    logic [CLASS_WIDTH-1:0]    w_cls;
    logic                      w_depth_ok;
    logic                      w_viol_ok;
    logic                      w_cleared;
    logic                      w_kcls_ok;

    assign w_cls = i_tok.cls;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_depth <= '0;
            r_kpos  <= '0;
            r_kcls  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_depth <= n_depth;
            r_kpos  <= n_kpos;
            r_kcls  <= n_kcls;
        end
    end

    always @* begin
        n_phase = r_phase;
        n_depth = r_depth;
        n_kpos  = r_kpos;
        n_kcls  = r_kcls;
        w_viol  = 1'b0;
        if (w_cls != CLS_SPACE) begin
            unique case (r_phase)
                PH_ALWAYS: begin
                    if (w_cls == CLS_BEGIN) begin
                        n_phase = PH_NORMAL;
                    end else if (w_cls == CLS_OPEN) begin
                        n_depth = DEPTH_WIDTH'(1);
                        n_phase = PH_COND;
                    end else if (w_cls != CLS_AT && w_cls != CLS_STAR) begin
                        w_viol = 1'b1;
                    end
                end
                PH_ELSE: begin
                    if (w_cls == CLS_IF) begin
                        if (kw_enabled(i_mask, w_cls)) begin
                            n_depth = '0;
                            n_kpos  = i_tok.pos;
                            n_kcls  = w_cls[KW_CLASS_WIDTH-1:0];
                            n_phase = PH_COND;
                        end else begin
                            n_phase = PH_NORMAL;
                        end
                    end else if (w_cls == CLS_BEGIN) begin
                        n_phase = PH_NORMAL;
                    end else begin
                        w_viol = 1'b1;
                    end
                end
                PH_COND: begin
                    if (w_cls == CLS_OPEN) begin
                        if (r_depth != DEPTH_MAX) begin
                            n_depth = r_depth + 1'b1;
                        end
                    end else if (w_cls == CLS_CLOSE) begin
                        if (r_depth != '0) begin
                            n_depth = r_depth - 1'b1;
                            if (r_depth == DEPTH_WIDTH'(1)) begin
                                n_phase = PH_EXPECT;
                            end
                        end
                    end
                end
                PH_EXPECT: begin
                    if (w_cls == CLS_BEGIN) begin
                        n_phase = PH_NORMAL;
                    end else begin
                        w_viol = 1'b1;
                    end
                end
                default: begin
                    if (kw_enabled(i_mask, w_cls)) begin
                        n_kpos = i_tok.pos;
                        n_kcls = w_cls[KW_CLASS_WIDTH-1:0];
                        case (w_cls) inside
                            CLS_ALWAYS: begin
                                n_depth = '0;
                                n_phase = PH_ALWAYS;
                            end
                            CLS_ELSE: begin
                                n_phase = PH_ELSE;
                            end
                            CLS_FF_PROC, CLS_FOREACH, CLS_FOR, CLS_IF, CLS_WHILE: begin
                                n_depth = '0;
                                n_phase = PH_COND;
                            end
                            default: begin
                                n_phase = PH_EXPECT;
                            end
                        endcase
                    end
                end
            endcase
            if (w_viol) begin
                n_depth = '0;
                n_phase = PH_NORMAL;
            end
        end
    end

    assign o_viol           = i_advance && w_viol;
    assign o_result.kw_pos  = r_kpos;
    assign o_result.kw_cls  = r_kcls;
    assign o_result.off_pos = i_tok.pos;
    assign o_result.off_cls = w_cls;

    assign w_depth_ok = (r_phase == PH_COND) || (r_depth == '0);
    assign w_viol_ok  = !o_viol || (r_phase == PH_ALWAYS) || (r_phase == PH_ELSE) ||
                        (r_phase == PH_EXPECT);
    assign w_cleared  = (r_phase == PH_NORMAL) && (r_depth == '0);
    assign w_kcls_ok  = (r_phase == PH_NORMAL) ||
                        (({1'b0, r_kcls} >= CLS_COMB_PROC) && ({1'b0, r_kcls} <= CLS_ELSE));

    `BESC_ASSERT_ALWAYS(a_depth_only_in_cond, w_depth_ok, "depth nonzero outside condition")
    `BESC_ASSERT_ALWAYS(a_viol_phase, w_viol_ok, "violation from a phase that never flags one")
    `BESC_ASSERT_NEXT(a_viol_to_normal, o_viol, w_cleared, "no return to normal phase")
    `BESC_ASSERT_ALWAYS(a_pending_keyword, w_kcls_ok, "pending keyword class out of range")

endmodule

// ===== design/besc_out.sv =====
module besc_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  besc_pkg::t_result i_result,
    output logic              o_ready,
    input  logic              i_m_ready,
    output logic              o_m_valid,
    output besc_pkg::t_result o_m_result
);
    import besc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_m_ready;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_valid  = r_valid;
    assign o_m_result = r_result;

endmodule

// ===== design/begin_end_style_checker_core.sv =====
// Begin/end style checker.
// Input stream s_axis: one classified source token per beat (class in tdata[4:0],
// position in tdata[36:5]). Output stream m_axis: one beat per violation, i.e. a
// block keyword whose following token (after skipping whitespace, condition
// parentheses, event controls or "else if") is not begin.
// APB port holds keyword_enable_mask at address 0; write it only while idle.
// Throughput: one token per clock sustained while m_axis accepts results. Each token is
// held in the input register, where the phase/depth logic evaluates it; a violation is
// then registered in the output register that drives m_axis.
// A token that causes no violation produces no output beat.
// Reset (i_rst_n low, synchronous) returns the checker to its normal phase with zero
// depth, empties both registers and restores the mask to all ones.
// When m_axis stalls with a result held, one more token is still taken into the input
// register and waits there; s_axis_tready stays low until m_axis takes the result.
module begin_end_style_checker_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [besc_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,  // token_class[4:0],
                                                                // token_position[36:5]
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [besc_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,  // keyword_position[31:0],
                                                                // keyword_class[35:32],
                                                                // offending_position[67:36],
                                                                // offending_class[72:68]
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [besc_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [besc_pkg::DATA_WIDTH-1:0]      pwdata,
    output logic [besc_pkg::DATA_WIDTH-1:0]      prdata,
    output logic                                 pready
);
    import besc_pkg::*;

    t_mask   w_mask;
    t_token  w_s_tok;
    t_token  w_tok;
    logic    w_tok_valid;
    logic    w_out_ready;
    logic    w_advance;
    logic    w_viol;
    t_result w_result;
    t_result w_m_result;

    assign w_s_tok.cls = s_axis_tdata[CLASS_WIDTH-1:0];
    assign w_s_tok.pos = s_axis_tdata[CLASS_WIDTH +: POSITION_WIDTH];

    besc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mask  (w_mask)
    );

    besc_in u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_tok     (w_s_tok),
        .o_ready   (s_axis_tready),
        .i_advance (w_advance),
        .o_valid   (w_tok_valid),
        .o_tok     (w_tok)
    );

    assign w_advance = w_tok_valid && w_out_ready;

    besc_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mask    (w_mask),
        .i_advance (w_advance),
        .i_tok     (w_tok),
        .o_viol    (w_viol),
        .o_result  (w_result)
    );

    besc_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_viol),
        .i_result   (w_result),
        .o_ready    (w_out_ready),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_m_result (w_m_result)
    );

    assign m_axis_tdata = {(OUT_TDATA_WIDTH - $bits(t_result))'(0), w_m_result};

endmodule

// ===== tb/sv/tb_begin_end_style_checker_core.sv =====
`timescale 1ns / 100ps

module tb_begin_end_style_checker_core;
    import besc_pkg::*;

    localparam logic [CLASS_WIDTH-1:0] CLS_LATCH_PROC   = 5'd3;
    localparam logic [CLASS_WIDTH-1:0] CLS_FOREVER      = 5'd4;
    localparam logic [CLASS_WIDTH-1:0] CLS_INITIAL      = 5'd5;
    localparam logic [CLASS_WIDTH-1:0] CLS_UNKNOWN_TOP  = 5'd31;

    localparam logic [ADDR_WIDTH-1:0] ADDR_MASK   = 3'd0;
    localparam logic [ADDR_WIDTH-1:0] ADDR_UNUSED = 3'd4;

    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_TOKENS  = 165;
    localparam int SETTLE_CYCLES = 4;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;   // token_class[4:0], token_position[36:5]
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;        // keyword_position[31:0], keyword_class[35:32],
                                                     // offending_position[67:36],
                                                     // offending_class[72:68]
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0]      paddr = '0;
    logic [DATA_WIDTH-1:0]      pwdata = '0;
    logic [DATA_WIDTH-1:0]      prdata;
    logic                       pready;

    begin_end_style_checker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // checker state as predicted
    t_mask                     kw_mask = MASK_RESET;
    t_phase                    chk_phase = PH_NORMAL;
    logic [DEPTH_WIDTH-1:0]    paren_level = '0;
    logic [POSITION_WIDTH-1:0] pend_pos = '0;
    logic [KW_CLASS_WIDTH-1:0] pend_cls = '0;

    t_token  pending_tokens[$];
    t_result expected_violations[$];
    int      mismatches = 0;
    int      phase_tokens = 0;

    function automatic bit keyword_on(input logic [CLASS_WIDTH-1:0] cls);
        logic [CLASS_WIDTH-1:0] off;
        off = cls - CLS_COMB_PROC;
        if (cls < CLS_COMB_PROC || cls > CLS_ELSE) begin
            return 1'b0;
        end
        return kw_mask[off[3:0]];
    endfunction

    function automatic bit predict_violation(input logic [CLASS_WIDTH-1:0] cls,
                                             input logic [POSITION_WIDTH-1:0] pos,
                                             output t_result res);
        bit flag;
        flag = 1'b0;
        res = '0;
        if (cls == CLS_SPACE) begin
            return 1'b0;
        end
        case (chk_phase)
            PH_ALWAYS: begin
                if (cls == CLS_OPEN) begin
                    paren_level = DEPTH_WIDTH'(1);
                    chk_phase = PH_COND;
                end else if (cls == CLS_BEGIN) begin
                    chk_phase = PH_NORMAL;
                end else if (cls != CLS_AT && cls != CLS_STAR) begin
                    flag = 1'b1;
                end
            end
            PH_ELSE: begin
                if (cls == CLS_IF) begin
                    if (keyword_on(cls)) begin
                        paren_level = '0;
                        pend_pos = pos;
                        pend_cls = cls[KW_CLASS_WIDTH-1:0];
                        chk_phase = PH_COND;
                    end else begin
                        chk_phase = PH_NORMAL;
                    end
                end else if (cls == CLS_BEGIN) begin
                    chk_phase = PH_NORMAL;
                end else begin
                    flag = 1'b1;
                end
            end
            PH_COND: begin
                if (cls == CLS_OPEN) begin
                    if (paren_level != DEPTH_MAX) paren_level++;
                end else if (cls == CLS_CLOSE && paren_level != 0) begin
                    paren_level--;
                    if (paren_level == 0) chk_phase = PH_EXPECT;
                end
            end
            PH_EXPECT: begin
                if (cls == CLS_BEGIN) chk_phase = PH_NORMAL;
                else flag = 1'b1;
            end
            default: begin
                if (!keyword_on(cls)) begin
                    return 1'b0;
                end
                pend_pos = pos;
                pend_cls = cls[KW_CLASS_WIDTH-1:0];
                if (cls == CLS_ALWAYS) begin
                    paren_level = '0;
                    chk_phase = PH_ALWAYS;
                end else if (cls == CLS_ELSE) begin
                    chk_phase = PH_ELSE;
                end else if (cls >= CLS_FF_PROC && cls <= CLS_WHILE) begin
                    paren_level = '0;
                    chk_phase = PH_COND;
                end else begin
                    chk_phase = PH_EXPECT;
                end
            end
        endcase
        if (flag) begin
            res.kw_pos = pend_pos;
            res.kw_cls = pend_cls;
            res.off_pos = pos;
            res.off_cls = cls;
            paren_level = '0;
            chk_phase = PH_NORMAL;
        end
        return flag;
    endfunction

    task automatic report_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %h, got %h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // token source: bursts with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin : drive_tokens
        t_result res;
        t_token  tok;
        bit      nv;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (predict_violation(s_axis_tdata[4:0], s_axis_tdata[36:5], res))
                    expected_violations.push_back(res);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                nv = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_tokens.size() != 0) begin
                    tok = pending_tokens.pop_front();
                    nv = 1'b1;
                    s_axis_tdata <= {3'b000, tok.pos, tok.cls};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
                s_axis_tvalid <= nv;
            end
        end
    end

    // violation sink: stall pattern changes mode whenever the mode_cycles countdown runs out
    int unsigned ready_mode = 0;
    int unsigned mode_cycles = 0;
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin : drain_violations
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[72:0]);
                if (expected_violations.size() == 0) begin
                    $display("%0t ns: violation beat expected none, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_violations.pop_front();
                    report_field("keyword_position", want.kw_pos, got.kw_pos);
                    report_field("keyword_class", 32'(want.kw_cls), 32'(got.kw_cls));
                    report_field("offending_position", want.off_pos, got.off_pos);
                    report_field("offending_class", 32'(want.off_cls), 32'(got.off_cls));
                end
            end
            if (mode_cycles == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_cycles = 97;
            end
            mode_cycles--;
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: begin
                    if (stall_left != 0) begin
                        stall_left--;
                        m_axis_tready <= 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(0, 15);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic cfg_write(input logic [ADDR_WIDTH-1:0] addr, input logic [DATA_WIDTH-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_MASK) kw_mask = data[MASK_WIDTH-1:0];
    endtask

    task automatic cfg_check_mask();
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_MASK;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        report_field("keyword_enable_mask", {{(DATA_WIDTH-MASK_WIDTH){1'b0}}, kw_mask}, prdata);
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mask(input t_mask m);
        logic [DATA_WIDTH-1:0] data;
        data = $urandom();
        data[MASK_WIDTH-1:0] = m;
        cfg_write(ADDR_MASK, data);
        cfg_check_mask();
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_tokens.size() != 0 || s_axis_tvalid || expected_violations.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_at(input logic [CLASS_WIDTH-1:0] c, input logic [POSITION_WIDTH-1:0] p);
        t_token t;
        t.cls = c;
        t.pos = p;
        pending_tokens.push_back(t);
        phase_tokens++;
    endtask

    task automatic put(input logic [CLASS_WIDTH-1:0] c);
        put_at(c, $urandom());
    endtask

    task automatic maybe_space();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put(CLS_SPACE);
    endtask

    // anything but a parenthesis
    task automatic put_filler();
        logic [CLASS_WIDTH-1:0] c;
        do c = CLASS_WIDTH'($urandom_range(0, 31));
        while (c == CLS_OPEN || c == CLS_CLOSE);
        put(c);
    endtask

    task automatic put_condition();
        int lvl;
        if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 0) put(CLS_CLOSE);
            else put_filler();
        end
        put(CLS_OPEN);
        lvl = 1;
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 3))
                0: begin
                    put(CLS_OPEN);
                    lvl++;
                end
                1: begin
                    if (lvl > 1) begin
                        put(CLS_CLOSE);
                        lvl--;
                    end else begin
                        put_filler();
                    end
                end
                default: put_filler();
            endcase
        end
        repeat (lvl) put(CLS_CLOSE);
        maybe_space();
    endtask

    task automatic put_block_start();
        if ($urandom_range(0, 6) != 0) put(CLS_BEGIN);
        else put(CLASS_WIDTH'($urandom_range(0, 31)));
    endtask

    task automatic put_construct();
        logic [CLASS_WIDTH-1:0] kw;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) put(CLASS_WIDTH'($urandom_range(0, 31)));
            return;
        end
        kw = CLASS_WIDTH'($urandom_range(CLS_COMB_PROC, CLS_ELSE));
        put(kw);
        maybe_space();
        if (kw == CLS_ALWAYS) begin
            repeat ($urandom_range(0, 2)) put(($urandom_range(0, 1) == 0) ? CLS_AT : CLS_STAR);
            if ($urandom_range(0, 3) != 0) put_condition();
        end else if (kw == CLS_ELSE) begin
            if ($urandom_range(0, 2) != 0) begin
                put(CLS_IF);
                maybe_space();
                put_condition();
            end
        end else if (kw >= CLS_FF_PROC && kw <= CLS_WHILE) begin
            put_condition();
        end
        put_block_start();
        maybe_space();
    endtask

    t_mask phase_masks[RANDOM_PHASES];

    initial begin
        phase_masks = '{11'h7FF, 11'h000, 11'h400, 11'h2AA, 11'h555, 11'h000, 11'h000};
        phase_masks[5] = t_mask'($urandom());
        phase_masks[6] = t_mask'($urandom());
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cfg_check_mask();

        // all keywords enabled
        put_at(CLS_COMB_PROC, '0);
        put_at(CLS_BEGIN, '1);
        put_at(CLS_INITIAL, '1);
        put(CLS_SPACE);
        put_at(CLS_OTHER, '0);
        put(CLS_IF);
        put(CLS_CLOSE);
        put(CLS_OPEN);
        put(CLS_CLOSE);
        put(CLS_BEGIN);
        put(CLS_ELSE);
        put(CLS_IF);
        put(CLS_OPEN);
        put(CLS_CLOSE);
        put(CLS_OTHER);
        put(CLS_ALWAYS);
        put(CLS_AT);
        put(CLS_STAR);
        put(CLS_BEGIN);
        put(CLS_ALWAYS);
        put(CLS_FOR);
        put(CLS_BEGIN);
        put(CLS_FOREVER);
        put(CLS_UNKNOWN_TOP);
        put(CLS_LATCH_PROC);
        put(CLS_BEGIN);
        put(CLS_FF_PROC);
        put(CLS_AT);
        put(CLS_OPEN);
        put(CLS_CLOSE);
        put(CLS_BEGIN);
        put(CLS_ELSE);
        put(CLS_BEGIN);
        put(CLS_FOREACH);
        put(CLS_OPEN);
        put(CLS_CLOSE);
        put(CLS_SPACE);
        put(CLS_BEGIN);
        // nesting deeper than the counter: saturates at its top
        put(CLS_WHILE);
        repeat (258) put(CLS_OPEN);
        repeat (255) put(CLS_CLOSE);
        put(CLS_OTHER);
        wait_idle();

        // write to an unused address, then disable if
        cfg_write(ADDR_UNUSED, '0);
        cfg_check_mask();
        set_mask(11'h77F);
        put(CLS_ELSE);
        put(CLS_IF);
        put(CLS_OTHER);
        put(CLS_IF);
        put(CLS_OTHER);
        put(CLS_FOR);
        put(CLS_OPEN);
        put(CLS_CLOSE);
        put(CLS_OTHER);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_mask(phase_masks[ph]);
            phase_tokens = 0;
            while (phase_tokens < PHASE_TOKENS) put_construct();
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/besc_pkg.sv
design/besc_cfg.sv
design/besc_in.sv
design/besc_fsm.sv
design/besc_out.sv
design/begin_end_style_checker_core.sv
tb/sv/tb_begin_end_style_checker_core.sv
